[rtl/core/cirt_pkg.sv]
package cirt_pkg;

  localparam int unsigned RegCountDefault = 256;

  localparam logic [7:0] SeedReset   = 8'h22;
  localparam logic [7:0] MaxWriteLen = 8'd252;
  localparam logic [7:0] ConstLo     = 8'h55;
  localparam logic [7:0] ConstHi     = 8'hAA;
  localparam logic [7:0] NoData      = 8'hFF;

  typedef enum logic [1:0] {
    CMD_ADDR  = 2'd0,
    CMD_RECV  = 2'd1,
    CMD_REQ   = 2'd2,
    CMD_LOCAL = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CMT_RD,
    ST_CMT_WR
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic cmt_rd;
    logic cmt_wr;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic commit_go;
    logic commit_last;
    logic out_busy;
  } dp_status_t;

  function automatic logic [7:0] read_mask(input logic [7:0] idx);
    logic hit;
    hit = (idx <= 8'h01) ||
          (idx >= 8'hC0 && idx <= 8'hC7) ||
          (idx >= 8'hD0 && idx <= 8'hD3) ||
          (idx >= 8'hE0 && idx <= 8'hE9) ||
          (idx >= 8'hF0);
    return hit ? 8'hFF : 8'h00;
  endfunction

  function automatic logic [7:0] write_mask(input logic [7:0] idx);
    return (idx == 8'h01) ? 8'hFF : 8'h00;
  endfunction

endpackage

[rtl/core/cirt_if.sv]
interface cirt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic [7:0] local_index;

  modport source(output valid, output cmd, output data_byte, output local_index, input ready);
  modport sink(input valid, input cmd, input data_byte, input local_index, output ready);
endinterface

interface cirt_out_if;
  logic       valid;
  logic       ready;
  logic       ack;
  logic [7:0] read_data;
  logic       reset_request;

  modport source(output valid, output ack, output read_data, output reset_request, input ready);
  modport sink(input valid, input ack, input read_data, input reset_request, output ready);
endinterface

[rtl/core/cirt_ctrl.sv]
module cirt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  cirt_pkg::dp_status_t  status_i,
  output logic                  in_ready_o,
  output cirt_pkg::dp_cmd_t     cmd_o
);

  cirt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cirt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      cirt_pkg::ST_IDLE: begin
        in_ready_o = !status_i.out_busy;
        if (in_valid_i && !status_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = cirt_pkg::ST_EXEC;
        end
      end
      cirt_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.commit_go) begin
          state_d = cirt_pkg::ST_CMT_RD;
        end else begin
          cmd_o.emit = 1'b1;
          state_d    = cirt_pkg::ST_IDLE;
        end
      end
      cirt_pkg::ST_CMT_RD: begin
        cmd_o.cmt_rd = 1'b1;
        state_d      = cirt_pkg::ST_CMT_WR;
      end
      cirt_pkg::ST_CMT_WR: begin
        cmd_o.cmt_wr = 1'b1;
        if (status_i.commit_last) begin
          cmd_o.emit = 1'b1;
          state_d    = cirt_pkg::ST_IDLE;
        end else begin
          state_d = cirt_pkg::ST_CMT_RD;
        end
      end
      default: begin
        state_d = cirt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/cirt_dp.sv]
module cirt_dp #(
  parameter int unsigned RegCount = cirt_pkg::RegCountDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cirt_pkg::dp_cmd_t    cmd_i,
  output cirt_pkg::dp_status_t status_o,
  input  logic [1:0]           in_cmd_i,
  input  logic [7:0]           in_data_i,
  input  logic [7:0]           in_index_i,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 out_ack_o,
  output logic [7:0]           out_read_data_o,
  output logic                 out_reset_request_o
);

  localparam int unsigned AW       = $clog2(RegCount);
  localparam logic [8:0]  RegCnt9  = 9'(RegCount);
  localparam logic [7:0]  LenLimit = 8'(RegCount - 3);
  localparam logic [7:0]  LenConst = 8'(RegCount - 2);

  cirt_pkg::cmd_e cmd_q;
  logic [7:0] data_q, index_q;

  logic [7:0] seed_q;
  logic [7:0] ptr_q, ptr_d;
  logic [7:0] bc_q, bc_d;
  logic [7:0] sum_q, sum_d;
  logic       armed_q, armed_d;
  logic [7:0] rl_q, rl_d;
  logic       rfc_q, rfc_d;
  logic [7:0] cnt_q, cnt_d;
  logic       ack_q, ack_d;
  logic [7:0] rd_q, rd_d;
  logic       out_valid_q;
  logic       out_rr_q;
  logic       rr_q, rr_d;

  logic [7:0]          rf_mem [RegCount];
  logic [RegCount-1:0] rf_vld_q;
  logic [7:0]          rf_rdata_q;
  logic                rf_rvld_q;
  logic                rf_we;
  logic [AW-1:0]       rf_waddr;
  logic [7:0]          rf_wdata;

  logic [7:0] fb_mem [256];
  logic [7:0] fb_rdata_q;
  logic [7:0] fb0_q, fb1_q, fb2_q;

  logic [7:0] bc_inc, want, sum_add, len, size, rf_word, v_reg, v_const, v;
  logic [8:0] expected, rend;
  logic       early, too_long, is_read, frame_done, req_ok, req_last, ptr_exists;
  logic       recv_exec, cmt_write;

  assign bc_inc     = bc_q + 8'd1;
  assign want       = 8'd0 - sum_q;
  assign sum_add    = sum_q + data_q;
  assign len        = (bc_q == 8'd1) ? data_q : fb1_q;
  assign size       = (bc_q == 8'd2) ? data_q : fb2_q;
  assign early      = bc_inc < 8'd2;
  assign too_long   = (len <= LenLimit) && (len > cirt_pkg::MaxWriteLen);
  assign is_read    = len > LenLimit;
  assign expected   = is_read ? 9'd4 : 9'd3 + {1'b0, len};
  assign frame_done = {1'b0, bc_inc} >= expected;
  assign recv_exec  = cmd_i.exec && (cmd_q == cirt_pkg::CMD_RECV);

  assign rend     = {1'b0, rl_q} + 9'd1;
  assign req_ok   = armed_q && !({1'b0, bc_q} > rend);
  assign req_last = {1'b0, bc_inc} == rend;

  assign ptr_exists = {1'b0, ptr_q} < RegCnt9;
  assign rf_word    = rf_rvld_q ? rf_rdata_q : 8'h00;
  assign v_reg      = ptr_exists ? (rf_word & cirt_pkg::read_mask(ptr_q)) : cirt_pkg::NoData;
  assign v_const    = (ptr_q == 8'd0) ? cirt_pkg::ConstLo :
                      (ptr_q == 8'd1) ? cirt_pkg::ConstHi : cirt_pkg::NoData;
  assign v          = rfc_q ? v_const : v_reg;

  assign status_o.commit_go   = recv_exec && !early && !too_long && frame_done &&
                                (want == data_q) && !is_read && (len != 8'd0);
  assign status_o.commit_last = cnt_q == 8'(fb1_q - 8'd1);
  assign status_o.out_busy    = out_valid_q;

  assign cmt_write = cmd_i.cmt_wr && ptr_exists &&
                     (cirt_pkg::write_mask(ptr_q) == 8'hFF);

  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = ptr_q[AW-1:0];
    rf_wdata = fb_rdata_q;
    if (cmd_i.exec && (cmd_q == cirt_pkg::CMD_LOCAL) && ({1'b0, index_q} < RegCnt9)) begin
      rf_we    = 1'b1;
      rf_waddr = index_q[AW-1:0];
      rf_wdata = data_q;
    end else if (cmt_write) begin
      rf_we = 1'b1;
    end
  end

  assign rr_d = (rf_we && (rf_waddr == AW'(1))) ? rf_wdata[7] : rr_q;

  always_comb begin
    ptr_d   = ptr_q;
    bc_d    = bc_q;
    sum_d   = sum_q;
    armed_d = armed_q;
    rl_d    = rl_q;
    rfc_d   = rfc_q;
    cnt_d   = cnt_q;
    ack_d   = ack_q;
    rd_d    = rd_q;
    if (cmd_i.exec) begin
      ack_d = 1'b1;
      rd_d  = cirt_pkg::NoData;
      case (cmd_q)
        cirt_pkg::CMD_ADDR: begin
          bc_d  = 8'd0;
          sum_d = seed_q;
        end
        cirt_pkg::CMD_RECV: begin
          bc_d  = bc_inc;
          sum_d = sum_add;
          if (!early) begin
            if (too_long) begin
              bc_d  = 8'd0;
              sum_d = seed_q;
              ack_d = 1'b0;
            end else if (frame_done) begin
              bc_d  = 8'd0;
              sum_d = seed_q;
              if (want != data_q) begin
                ack_d = 1'b0;
              end else begin
                ptr_d = fb0_q;
                cnt_d = 8'd0;
                if (is_read) begin
                  armed_d = 1'b1;
                  rl_d    = size;
                  rfc_d   = len == LenConst;
                end
              end
            end
          end
        end
        cirt_pkg::CMD_REQ: begin
          if (req_ok) begin
            bc_d = bc_inc;
            if (req_last) begin
              armed_d = 1'b0;
              rl_d    = 8'd0;
              rfc_d   = 1'b0;
              rd_d    = want;
            end else begin
              rd_d  = v;
              ptr_d = ptr_q + 8'd1;
              sum_d = sum_q + v;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.cmt_wr) begin
      ptr_d = ptr_q + 8'd1;
      cnt_d = cnt_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= cirt_pkg::SeedReset;
      ptr_q       <= '0;
      bc_q        <= '0;
      sum_q       <= '0;
      armed_q     <= 1'b0;
      rl_q        <= '0;
      rfc_q       <= 1'b0;
      cnt_q       <= '0;
      ack_q       <= 1'b1;
      rd_q        <= cirt_pkg::NoData;
      out_valid_q <= 1'b0;
      out_rr_q    <= 1'b0;
      rr_q        <= 1'b0;
      rf_vld_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      ptr_q   <= ptr_d;
      bc_q    <= bc_d;
      sum_q   <= sum_d;
      armed_q <= armed_d;
      rl_q    <= rl_d;
      rfc_q   <= rfc_d;
      cnt_q   <= cnt_d;
      ack_q   <= ack_d;
      rd_q    <= rd_d;
      rr_q    <= rr_d;
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        out_rr_q    <= rr_d;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q      <= cirt_pkg::cmd_e'(in_cmd_i);
      data_q     <= in_data_i;
      index_q    <= in_index_i;
      rf_rdata_q <= rf_mem[ptr_q[AW-1:0]];
      rf_rvld_q  <= rf_vld_q[ptr_q[AW-1:0]];
    end
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (recv_exec) begin
      fb_mem[bc_q] <= data_q;
      if (bc_q == 8'd0) begin
        fb0_q <= data_q;
      end
      if (bc_q == 8'd1) begin
        fb1_q <= data_q;
      end
      if (bc_q == 8'd2) begin
        fb2_q <= data_q;
      end
    end
    if (cmd_i.cmt_rd) begin
      fb_rdata_q <= fb_mem[8'(8'd2 + cnt_q)];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_ack_o           = ack_q;
  assign out_read_data_o     = rd_q;
  assign out_reset_request_o = out_rr_q;

endmodule

[rtl/core/checksummed_i2c_register_target_top.sv]
// Each transaction is accepted in the idle state, runs in the exec state, and its result is then registered.
// A committed write frame walks the buffer through a read and a write state per data byte (up to 252 bytes).
// One transaction is in flight at a time; the next is taken once the result has left.
// The frame buffer and register file memories allow one access per cycle each.
// Reset is asynchronous and active low; register contents read as zero at once.
module checksummed_i2c_register_target_top #(
  parameter int unsigned RegCount = cirt_pkg::RegCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  cirt_in_if.sink           in_i,
  cirt_out_if.source        out_o
);

  cirt_pkg::dp_cmd_t    dp_cmd;
  cirt_pkg::dp_status_t dp_status;

  cirt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (dp_status),
    .in_ready_o (in_i.ready),
    .cmd_o      (dp_cmd)
  );

  cirt_dp #(
    .RegCount (RegCount)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .status_o            (dp_status),
    .in_cmd_i            (in_i.cmd),
    .in_data_i           (in_i.data_byte),
    .in_index_i          (in_i.local_index),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .out_ready_i         (out_o.ready),
    .out_valid_o         (out_o.valid),
    .out_ack_o           (out_o.ack),
    .out_read_data_o     (out_o.read_data),
    .out_reset_request_o (out_o.reset_request)
  );

endmodule

[rtl/core/cirt_checker.sv]
module cirt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_cmd_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_ack_i,
  input logic [7:0] out_read_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_no_accept_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !out_valid_i)
    else $error("Transaction accepted while a result is pending.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("Ready stayed high after an accepted transaction.");

  a_short_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_cmd_i != cirt_pkg::CMD_RECV) |=> ##1 out_valid_i)
    else $error("Result missing two cycles after a non-receive transaction.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_ack_i) && $stable(out_read_data_i))
    else $error("Stalled result changed.");

endmodule

bind checksummed_i2c_register_target_top cirt_checker u_cirt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_cmd_i        (in_i.cmd),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_ack_i       (out_o.ack),
  .out_read_data_i (out_o.read_data)
);

[tb/tb_checksummed_i2c_register_target_top.sv]
`timescale 1ns / 1ps

module tb_checksummed_i2c_register_target_top;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainCycles = 600;
  localparam int unsigned LongHoldCycles = 400;

  typedef struct {
    cirt_pkg::cmd_e cmd;
    logic [7:0]     data_byte;
    logic [7:0]     local_index;
    bit             typed;
    logic           t_ack;
    logic [7:0]     t_read_data;
    logic           t_reset_request;
  } event_t;

  typedef struct {
    logic       ack;
    logic [7:0] read_data;
    logic       reset_request;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  cirt_in_if in_if ();
  cirt_out_if out_if ();

  checksummed_i2c_register_target_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [7:0] m_seed;
  logic [7:0] m_regs [256];
  logic [7:0] m_fbuf [256];
  logic [7:0] m_ptr, m_count, m_sum, m_rlen;
  logic       m_armed, m_from_const;

  event_t    event_q[$];
  response_t response_q[$];
  event_t    cur_event;
  int        errors = 0;
  int        cycles = 0;
  bit        hold_go = 1'b0;
  logic [7:0] gen_seed = cirt_pkg::SeedReset;

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd = cirt_pkg::CMD_ADDR;
    in_if.data_byte = 8'h00;
    in_if.local_index = 8'h00;
    out_if.ready = 1'b0;
  end

  function automatic void model_reset();
    m_seed = cirt_pkg::SeedReset;
    for (int i = 0; i < 256; i++) begin
      m_regs[i] = 8'h00;
      m_fbuf[i] = 8'h00;
    end
    m_ptr = 0; m_count = 0; m_sum = 0; m_rlen = 0;
    m_armed = 0; m_from_const = 0;
  endfunction

  function automatic logic [7:0] rmask_of(input logic [7:0] i);
    if (i <= 8'h01 || (i >= 8'hC0 && i <= 8'hC7) || (i >= 8'hD0 && i <= 8'hD3) ||
        (i >= 8'hE0 && i <= 8'hE9) || i >= 8'hF0) return 8'hFF;
    return 8'h00;
  endfunction

  function automatic void frame_restart();
    m_count = 0;
    m_sum = m_seed;
  endfunction

  function automatic logic receive_byte(input logic [7:0] d);
    logic [7:0] want, len, v, m;
    int expected;
    m_fbuf[m_count] = d;
    m_count = m_count + 8'd1;
    want = 8'd0 - m_sum;
    m_sum = m_sum + d;
    if (m_count < 2) return 1'b1;
    len = m_fbuf[1];
    if (len <= 8'd253 && len > cirt_pkg::MaxWriteLen) begin
      frame_restart();
      return 1'b0;
    end
    expected = (len > 8'd253) ? 4 : 3 + int'(len);
    if (int'(m_count) < expected) return 1'b1;
    if (want != d) begin
      frame_restart();
      return 1'b0;
    end
    frame_restart();
    m_ptr = m_fbuf[0];
    if (len > 8'd253) begin
      m_armed = 1'b1;
      m_rlen = m_fbuf[2];
      m_from_const = (len == 8'd254);
      return 1'b1;
    end
    for (int i = 0; i < int'(len); i++) begin
      v = m_fbuf[(2 + i) & 8'hFF];
      m = (m_ptr == 8'h01) ? 8'hFF : 8'h00;
      m_regs[m_ptr] = (m_regs[m_ptr] & ~m) | (v & m);
      m_ptr = m_ptr + 8'd1;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] request_byte();
    int endc;
    logic [7:0] v;
    if (!m_armed) return cirt_pkg::NoData;
    endc = int'(m_rlen) + 1;
    if (int'(m_count) > endc) return cirt_pkg::NoData;
    m_count = m_count + 8'd1;
    if (int'(m_count) == endc) begin
      m_armed = 0; m_rlen = 0; m_from_const = 0;
      return 8'd0 - m_sum;
    end
    v = cirt_pkg::NoData;
    if (!m_from_const) v = m_regs[m_ptr] & rmask_of(m_ptr);
    else if (m_ptr == 8'd0) v = cirt_pkg::ConstLo;
    else if (m_ptr == 8'd1) v = cirt_pkg::ConstHi;
    m_ptr = m_ptr + 8'd1;
    m_sum = m_sum + v;
    return v;
  endfunction

  function automatic response_t target_predict(input event_t e);
    response_t r;
    r.ack = 1'b1;
    r.read_data = cirt_pkg::NoData;
    case (e.cmd)
      cirt_pkg::CMD_ADDR: frame_restart();
      cirt_pkg::CMD_RECV: r.ack = receive_byte(e.data_byte);
      cirt_pkg::CMD_REQ: r.read_data = request_byte();
      default: m_regs[e.local_index] = e.data_byte;
    endcase
    r.reset_request = m_regs[1][7];
    return r;
  endfunction

  function automatic void push_event(input cirt_pkg::cmd_e c, input logic [7:0] d,
                                     input logic [7:0] idx);
    event_t e;
    e.cmd = c; e.data_byte = d; e.local_index = idx;
    e.typed = 0; e.t_ack = 1; e.t_read_data = cirt_pkg::NoData; e.t_reset_request = 0;
    event_q.push_back(e);
  endfunction

  function automatic void gen_frame();
    int kind, len, size;
    logic [7:0] sum, ptr, b;
    kind = $urandom_range(0, 99);
    ptr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    if (kind < 45) begin
      push_event(cirt_pkg::CMD_ADDR, 8'($urandom), 8'($urandom));
      len = $urandom_range(0, 99);
      len = (len < 3) ? 252 : (len < 5) ? 253 : $urandom_range(0, 8);
      sum = gen_seed + ptr + 8'(len);
      push_event(cirt_pkg::CMD_RECV, ptr, 8'($urandom));
      push_event(cirt_pkg::CMD_RECV, 8'(len), 8'($urandom));
      if (len == 253) return;
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom);
        sum = sum + b;
        push_event(cirt_pkg::CMD_RECV, b, 8'($urandom));
      end
      push_event(cirt_pkg::CMD_RECV,
                 ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'd0 - sum, 8'($urandom));
    end else if (kind < 75) begin
      push_event(cirt_pkg::CMD_ADDR, 8'($urandom), 8'($urandom));
      len = $urandom_range(254, 255);
      size = ($urandom_range(0, 99) == 0) ? 255 : $urandom_range(0, 6);
      sum = gen_seed + ptr + 8'(len) + 8'(size);
      push_event(cirt_pkg::CMD_RECV, ptr, 8'($urandom));
      push_event(cirt_pkg::CMD_RECV, 8'(len), 8'($urandom));
      push_event(cirt_pkg::CMD_RECV, 8'(size), 8'($urandom));
      push_event(cirt_pkg::CMD_RECV,
                 ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0 - sum, 8'($urandom));
      for (int i = 0; i < (size % 16) + 1 + $urandom_range(0, 2); i++)
        push_event(cirt_pkg::CMD_REQ, 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 3) == 0)
        for (int i = 0; i < $urandom_range(1, 5); i++)
          push_event(cirt_pkg::CMD_RECV, 8'($urandom), 8'($urandom));
    end else if (kind < 85) begin
      push_event(cirt_pkg::CMD_LOCAL, 8'($urandom),
                 ($urandom_range(0, 2) == 0) ? 8'h01 : 8'($urandom));
    end else begin
      push_event(cirt_pkg::cmd_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
    end
  endfunction

  // Directed stimulus; typed rows carry an expectation that can be read at a glance.
  typedef struct {
    cirt_pkg::cmd_e cmd;
    logic [7:0]     d;
    logic [7:0]     idx;
    bit             typed;
    logic           ack;
    logic [7:0]     rd;
    logic           rr;
  } row_t;

  localparam int NumRows = 29;
  row_t rows [NumRows] = '{
    '{cirt_pkg::CMD_REQ,   8'h00, 8'h00, 1, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_ADDR,  8'hFF, 8'hFF, 1, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'h00, 8'h00, 1, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'd253, 8'h00, 1, 1'b0, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_ADDR,  8'h00, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'h01, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'h01, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'hFF, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'hDD, 8'h00, 0, 1'b1, 8'hFF, 1'b1},
    '{cirt_pkg::CMD_LOCAL, 8'h00, 8'h01, 1, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_LOCAL, 8'hFF, 8'hFF, 1, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_LOCAL, 8'h80, 8'h01, 1, 1'b1, 8'hFF, 1'b1},
    '{cirt_pkg::CMD_ADDR,  8'h00, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'h00, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'd254, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'h03, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'hDD, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_REQ,   8'h00, 8'h00, 1, 1'b1, 8'h55, 1'b1},
    '{cirt_pkg::CMD_REQ,   8'h00, 8'h00, 1, 1'b1, 8'hAA, 1'b1},
    '{cirt_pkg::CMD_REQ,   8'h00, 8'h00, 1, 1'b1, 8'hFF, 1'b1},
    '{cirt_pkg::CMD_REQ,   8'h00, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_REQ,   8'h00, 8'h00, 1, 1'b1, 8'hFF, 1'b1},
    '{cirt_pkg::CMD_ADDR,  8'h00, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'hFE, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'hFF, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'h02, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_RECV,  8'hDF, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_REQ,   8'h00, 8'h00, 0, 1'b1, 8'hFF, 1'b0},
    '{cirt_pkg::CMD_REQ,   8'h00, 8'h00, 0, 1'b1, 8'hFF, 1'b0}
  };

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_if.ready) begin
    end else if (gap_left > 0) begin
      gap_left--;
      in_if.valid <= 1'b0;
    end else if (event_q.size() > 0) begin
      event_t e;
      e = event_q.pop_front();
      cur_event <= e;
      in_if.cmd <= e.cmd;
      in_if.data_byte <= e.data_byte;
      in_if.local_index <= e.local_index;
      in_if.valid <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off.
  int mode_left = 0;
  int stall_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      if (hold_left == 0) hold_left = LongHoldCycles;
      hold_left--;
      if (hold_left == 0) hold_done = 1'b1;
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 96);
        stall_mode = $urandom_range(0, 2);
      end
      mode_left--;
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // Scoreboard: results are checked before the accepted transaction is predicted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        response_t w;
        if (response_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result ack=%0b read_data=%02h reset_request=%0b",
                   $time, out_if.ack, out_if.read_data, out_if.reset_request);
        end else begin
          w = response_q.pop_front();
          if (out_if.ack !== w.ack) begin
            errors++;
            $display("%0t: ack expected %0b actual %0b", $time, w.ack, out_if.ack);
          end
          if (out_if.read_data !== w.read_data) begin
            errors++;
            $display("%0t: read_data expected %02h actual %02h", $time, w.read_data,
                     out_if.read_data);
          end
          if (out_if.reset_request !== w.reset_request) begin
            errors++;
            $display("%0t: reset_request expected %0b actual %0b", $time, w.reset_request,
                     out_if.reset_request);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        response_t p;
        p = target_predict(cur_event);
        if (cur_event.typed) begin
          p.ack = cur_event.t_ack;
          p.read_data = cur_event.t_read_data;
          p.reset_request = cur_event.t_reset_request;
        end
        response_q.push_back(p);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("checksummed_i2c_register_target_top verification failed");
      $finish;
    end
  end

  task automatic drain();
    while (event_q.size() > 0 || in_if.valid || response_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [7:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    m_seed = v;
    gen_seed = v;
  endtask

  logic [7:0] seeds [5];

  initial begin
    event_t e;
    logic [7:0] sum, b;
    model_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) begin
      e.cmd = rows[i].cmd; e.data_byte = rows[i].d; e.local_index = rows[i].idx;
      e.typed = rows[i].typed; e.t_ack = rows[i].ack;
      e.t_read_data = rows[i].rd; e.t_reset_request = rows[i].rr;
      event_q.push_back(e);
    end
    // A maximum-length write fills the frame buffer before any stale-count traffic.
    push_event(cirt_pkg::CMD_ADDR, 8'h00, 8'h00);
    push_event(cirt_pkg::CMD_RECV, 8'h10, 8'h00);
    push_event(cirt_pkg::CMD_RECV, cirt_pkg::MaxWriteLen, 8'h00);
    sum = gen_seed + 8'h10 + cirt_pkg::MaxWriteLen;
    for (int i = 0; i < cirt_pkg::MaxWriteLen; i++) begin
      b = 8'($urandom);
      sum = sum + b;
      push_event(cirt_pkg::CMD_RECV, b, 8'($urandom));
    end
    push_event(cirt_pkg::CMD_RECV, 8'd0 - sum, 8'h00);
    drain();
    seeds = '{8'h00, 8'hFF, 8'($urandom), cirt_pkg::SeedReset, 8'($urandom)};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_seed(seeds[ph - 1]);
      while (event_q.size() < 260) gen_frame();
      if (ph == 1) begin
        while (event_q.size() > 200) @(posedge clk_i);
        hold_go = 1'b1;
      end
      drain();
    end
    if (errors == 0) begin
      $display("checksummed_i2c_register_target_top verification clean");
    end else begin
      $display("checksummed_i2c_register_target_top verification failed");
    end
    $finish;
  end

endmodule
